// ===== design/match_timer_with_prescaler_macros.svh =====
// Assertion macros shared by the match timer checker
`ifndef MATCH_TIMER_WITH_PRESCALER_MACROS_SVH
`define MATCH_TIMER_WITH_PRESCALER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define MTP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define MTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mtp_pkg.sv =====
// Types and constants of the match timer with prescaler
package mtp_pkg;

    localparam int unsigned NUM_CHAN   = 4;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned CTRL_W     = 3;
    localparam int unsigned MCTRL_W    = NUM_CHAN * CTRL_W;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;

    // Bit positions within one channel's control field
    localparam int unsigned CTRL_INT_BIT   = 0;
    localparam int unsigned CTRL_RESET_BIT = 1;
    localparam int unsigned CTRL_STOP_BIT  = 2;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_CTRL  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // Register indexes (byte address is four times the index)
    typedef enum logic [2:0] {
        REG_PRESCALE = 3'd0,
        REG_MATCH0   = 3'd1,
        REG_MATCH1   = 3'd2,
        REG_MATCH2   = 3'd3,
        REG_MATCH3   = 3'd4,
        REG_MCTRL    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
        logic       enable_bit;
        logic       reset_bit;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]                prescale_limit;
        logic [NUM_CHAN-1:0][CNT_W-1:0]  match_value;
        logic [MCTRL_W-1:0]              match_control;
    } cfg_t;

endpackage

// ===== design/mtp_in_if.sv =====
// Input channel of the match timer: one word per item
interface mtp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] channel;
    logic       enable_bit;
    logic       reset_bit;

    modport source (output valid, kind, channel, enable_bit, reset_bit, input ready);
    modport sink   (input valid, kind, channel, enable_bit, reset_bit, output ready);
endinterface

// ===== design/mtp_out_if.sv =====
// Result channel of the match timer: one word per item
interface mtp_out_if;
    logic        valid;
    logic        ready;
    logic        flag_value;
    logic [3:0]  flags;
    logic        interrupt_line;
    logic [31:0] count_now;

    modport source (output valid, flag_value, flags, interrupt_line, count_now, input ready);
    modport sink   (input valid, flag_value, flags, interrupt_line, count_now, output ready);
endinterface

// ===== design/match_timer_with_prescaler.sv =====
// Match timer with prescaler: top level
//
// Use: each input word is a tick, a control write (enable, hold in reset),
// a flag clear (write one to clear) or a flag read, chosen by kind. Every
// word gives exactly one result word: the read flag, all four interrupt
// flags, the interrupt line and the timer count after the word.
// Configuration (prescale limit, four match values, match control) sits
// on the APB port at byte addresses 0x00 to 0x14; pready is always high.
// Path: an accepted word is held in the input register; when the core takes it,
// the result word is registered. Throughput: one word per cycle while the
// result channel is not stalled; the timer state is read and written once per
// word by the update in the core.
// Reset: rst_n clears the configuration, both counts, the flags, and the
// enable and hold bits; both channels come up empty.
// Stall: while the receiver holds ready low, the result word holds and one
// further word is taken into the input register; after that the input
// channel's ready stays low until the result word is taken.
module match_timer_with_prescaler
    import mtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mtp_in_if.sink                in_ch,
    mtp_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t  cfg;
    item_t item;
    logic  item_vld;
    logic  take;

    mtp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mtp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    mtp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (item_vld),
        .item     (item),
        .cfg      (cfg),
        .take     (take),
        .out_ch   (out_ch)
    );

endmodule

// ===== design/mtp_apb_regs.sv =====
// APB configuration registers of the match timer
module mtp_apb_regs
    import mtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PRESCALE: cfg_reg.prescale_limit <= pwdata;
                REG_MATCH0:   cfg_reg.match_value[0] <= pwdata;
                REG_MATCH1:   cfg_reg.match_value[1] <= pwdata;
                REG_MATCH2:   cfg_reg.match_value[2] <= pwdata;
                REG_MATCH3:   cfg_reg.match_value[3] <= pwdata;
                REG_MCTRL:    cfg_reg.match_control <= pwdata[MCTRL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            REG_PRESCALE: prdata = cfg_reg.prescale_limit;
            REG_MATCH0:   prdata = cfg_reg.match_value[0];
            REG_MATCH1:   prdata = cfg_reg.match_value[1];
            REG_MATCH2:   prdata = cfg_reg.match_value[2];
            REG_MATCH3:   prdata = cfg_reg.match_value[3];
            REG_MCTRL:    prdata = {{(APB_DATA_W-MCTRL_W){1'b0}}, cfg_reg.match_control};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== design/mtp_in_stage.sv =====
// Input register of the match timer
module mtp_in_stage
    import mtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mtp_in_if.sink    in_ch,
    input  logic      take,
    output logic      item_vld,
    output item_t     item
);

    logic  vld_reg;
    item_t item_reg;

    // Accept a word whenever the held one is empty or moves on this cycle
    assign in_ch.ready = !vld_reg || take;
    assign item_vld    = vld_reg;
    assign item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            vld_reg <= in_ch.valid;
        end
    end

    // Capture the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            item_reg.kind       <= in_ch.kind;
            item_reg.channel    <= in_ch.channel;
            item_reg.enable_bit <= in_ch.enable_bit;
            item_reg.reset_bit  <= in_ch.reset_bit;
        end
    end

endmodule

// ===== design/mtp_core.sv =====
// Timer state, match logic and result register of the match timer
module mtp_core
    import mtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_vld,
    input  item_t     item,
    input  cfg_t      cfg,
    output logic      take,
    mtp_out_if.source out_ch
);

    logic [CNT_W-1:0]    timer_count_reg, timer_count_next;
    logic [CNT_W-1:0]    prescale_count_reg, prescale_count_next;
    logic [NUM_CHAN-1:0] flags_reg, flags_next;
    logic                running_reg, running_next;
    logic                held_reg, held_next;

    logic                out_vld_reg;
    logic                flag_value_reg, flag_value_next;
    logic [NUM_CHAN-1:0] out_flags_reg;
    logic [CNT_W-1:0]    count_now_reg;

    logic [NUM_CHAN-1:0] hit;
    logic [NUM_CHAN-1:0] ctl_int, ctl_rst, ctl_stop;
    logic                do_reset, do_stop;
    kind_t               kind;

    assign kind = kind_t'(item.kind);
    assign take = item_vld && (!out_vld_reg || out_ch.ready);

    // Compare the count with every channel and split the control fields
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            hit[i]      = (cfg.match_value[i] == timer_count_reg);
            ctl_int[i]  = cfg.match_control[CTRL_W*i + CTRL_INT_BIT];
            ctl_rst[i]  = cfg.match_control[CTRL_W*i + CTRL_RESET_BIT];
            ctl_stop[i] = cfg.match_control[CTRL_W*i + CTRL_STOP_BIT];
        end
    end

    assign do_reset = |(hit & ctl_rst);
    assign do_stop  = |(hit & ctl_stop);

    // Work out the state after the held word
    always_comb
    begin
        timer_count_next    = timer_count_reg;
        prescale_count_next = prescale_count_reg;
        flags_next          = flags_reg;
        running_next        = running_reg;
        held_next           = held_reg;
        flag_value_next     = 1'b0;
        unique case (kind)
            KIND_TICK:
            begin
                if (held_reg)
                begin
                    timer_count_next    = '0;
                    prescale_count_next = '0;
                end
                else if (running_reg)
                begin
                    if (prescale_count_reg < cfg.prescale_limit)
                    begin
                        prescale_count_next = prescale_count_reg + 1'b1;
                    end
                    else
                    begin
                        prescale_count_next = '0;
                        flags_next          = flags_reg | (hit & ctl_int);
                        if (do_reset)
                        begin
                            timer_count_next = '0;
                        end
                        else if (!do_stop)
                        begin
                            timer_count_next = timer_count_reg + 1'b1;
                        end
                        if (do_stop)
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
            end
            KIND_CTRL:
            begin
                running_next = item.enable_bit;
                held_next    = item.reset_bit;
                if (item.reset_bit)
                begin
                    timer_count_next    = '0;
                    prescale_count_next = '0;
                end
            end
            KIND_CLEAR:
            begin
                flags_next[item.channel] = 1'b0;
            end
            KIND_READ:
            begin
                flag_value_next = flags_reg[item.channel];
            end
        endcase
    end

    // Advance the timer state as each word passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_count_reg    <= '0;
            prescale_count_reg <= '0;
            flags_reg          <= '0;
            running_reg        <= 1'b0;
            held_reg           <= 1'b0;
        end
        else if (take)
        begin
            timer_count_reg    <= timer_count_next;
            prescale_count_reg <= prescale_count_next;
            flags_reg          <= flags_next;
            running_reg        <= running_next;
            held_reg           <= held_next;
        end
    end

    // Hold the result word until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flag_value_reg <= flag_value_next;
            out_flags_reg  <= flags_next;
            count_now_reg  <= timer_count_next;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.flag_value     = flag_value_reg;
    assign out_ch.flags          = out_flags_reg;
    assign out_ch.interrupt_line = |out_flags_reg;
    assign out_ch.count_now      = count_now_reg;

endmodule

// ===== design/mtp_checker.sv =====
// Port-level checks of the match timer, bound to the top level
`include "match_timer_with_prescaler_macros.svh"

module mtp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_flag_value,
    input logic [3:0]  out_flags,
    input logic [31:0] out_count_now
);

    // Input is refused only while a result word is stalled
    `MTP_ASSERT_SAME(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input refused without output stall")

    // A new result appears only for a word accepted through the input register
    `MTP_ASSERT_SAME(a_out_rise, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without matching input word")

    // A stalled result word holds
    `MTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_flag_value) && $stable(out_flags) && $stable(out_count_now), "stalled result changed")

endmodule

bind match_timer_with_prescaler mtp_checker u_mtp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_flag_value (out_ch.flag_value),
    .out_flags      (out_ch.flags),
    .out_count_now  (out_ch.count_now)
);
